/* rtl/rle_run_to_raster_segments_macros.svh */
// Assertion macros for the checker file of the run-length raster decoder.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef RLE_RUN_TO_RASTER_SEGMENTS_MACROS_SVH
`define RLE_RUN_TO_RASTER_SEGMENTS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rle_r2s: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rle_r2s: next-cycle property failed");

`endif

/* rtl/rle_r2s_pkg.sv */
// Package of the run-length raster decoder: item types, register indexes,
// sequencer states and fixed widths. Depends on nothing.
`default_nettype none

package rle_r2s_pkg;

    // Width of the internal column/row arithmetic; covers raster sizes up to 1024.
    localparam int CALC_W = 12;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORIGIN_X = 1'b0;
    localparam t_cfg_idx CFG_ORIGIN_Y = 1'b1;

    typedef struct packed {
        logic [7:0] run_count;
        logic [7:0] run_color;
        logic       last_pair;
    } t_run_in;

    typedef struct packed {
        logic [10:0] seg_x;
        logic [10:0] seg_y;
        logic [7:0]  seg_length;
        logic [8:0]  seg_rows;
        logic        seg_white;
        logic        frame_done;
        logic        item_last;
    } t_seg_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_BODY_CHK,
        ST_DIV,
        ST_BODY,
        ST_TAIL,
        ST_FROW,
        ST_FBLK,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

/* rtl/rle_run_to_raster_segments.sv */
// Run-length raster decoder: turns (count, colour) runs into placed drawing segments.
// Depends on rle_r2s_pkg for the item types, register indexes and sequencer states.
//
// Use: the input channel (i_in_valid / o_in_ready / i_in) takes one run per item;
// the output channel (o_out_valid / i_out_ready / o_out) gives the segments that
// the run causes, up to five, the final one marked item_last. A run of zero
// pixels with a nonzero colour gives none, unless it is the last pair.
// The origin registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user writes them only while the block is idle; the block does not enforce it.
// Sequencing: an item walks the sequencer through head, body check, tail, final row,
// final block and finish states back to idle, and no item is taken before it is back;
// a run that covers whole rows adds the states for the row count from a reciprocal
// multiplication and for the block segment. An item after a complete frame is taken
// and dropped at once, but a last pair still rewinds the cursor.
// o_in_ready is high only while the sequencer is idle.
// A stalled receiver holds the output register, and the sequencer waits in the
// state that owns the next segment for as long as the stall lasts; nothing is dropped.
// Reset clears the cursor, the frame-finished flag, both origins and the output
// valid flag; the block is ready from the first cycle after reset is released.
`default_nettype none

module rle_run_to_raster_segments
    import rle_r2s_pkg::*;
#(
    parameter int RASTER_WIDTH  = 240,
    parameter int RASTER_HEIGHT = 320
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_run_in  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_seg_out      o_out,
    input  wire logic     i_cfg_we,
    input  wire t_cfg_idx i_cfg_idx,
    input  wire logic [9:0] i_cfg_data
);

    localparam int XW = $clog2(RASTER_WIDTH + 1);
    localparam int YW = $clog2(RASTER_HEIGHT + 1);
    localparam logic [CALC_W-1:0] W_C = CALC_W'(RASTER_WIDTH);
    localparam logic [CALC_W-1:0] H_C = CALC_W'(RASTER_HEIGHT);
    // Reciprocal of the raster width, exact for every 8-bit run count.
    localparam int DIV_K = 8 + $clog2(RASTER_WIDTH);
    localparam int DIV_M = ((1 << DIV_K) + RASTER_WIDTH - 1) / RASTER_WIDTH;

    t_state          r_state, n_state;
    logic [XW-1:0]   r_x, n_x;
    logic [YW-1:0]   r_y, n_y;
    logic [7:0]      r_rem, n_rem;
    logic            r_white, n_white;
    logic            r_fill, n_fill;
    logic            r_last, n_last;
    logic            r_ff, n_ff;
    logic [7:0]      r_dv, n_dv;
    logic [7:0]      r_pr, n_pr;
    logic            r_cnt, n_cnt;
    logic [9:0]      r_org_x, r_org_y;
    logic            r_out_valid;
    t_seg_out        r_out;

    logic            in_acc, slot_free, emit;
    t_seg_out        seg;
    logic            more, done;

    logic [CALC_W-1:0] x_e, y_e, rem_e;
    logic [CALC_W-1:0] wx, hp, hx, hx_n, hy_n, hrem;
    logic              wrap;
    logic [CALC_W-1:0] rows_q, room, rows, by;
    logic [17:0]       prod, q_full;
    logic [CALC_W-1:0] pr_c;
    logic              head_go, body_go, tail_go, frow_go, fblk_go, y_in;

    function automatic t_seg_out mk_seg(
        input logic [9:0]        org_x,
        input logic [9:0]        org_y,
        input logic [CALC_W-1:0] sx,
        input logic [CALC_W-1:0] sy,
        input logic [CALC_W-1:0] len,
        input logic [CALC_W-1:0] nrows,
        input logic              white,
        input logic              fdone,
        input logic              ilast
    );
        t_seg_out          s;
        logic [CALC_W-1:0] ax, ay;
        ax           = CALC_W'(org_x) + sx;
        ay           = CALC_W'(org_y) + sy;
        s.seg_x      = ax[10:0];
        s.seg_y      = ay[10:0];
        s.seg_length = len[7:0];
        s.seg_rows   = nrows[8:0];
        s.seg_white  = white;
        s.frame_done = fdone;
        s.item_last  = ilast;
        return s;
    endfunction

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    assign x_e   = CALC_W'(r_x);
    assign y_e   = CALC_W'(r_y);
    assign rem_e = CALC_W'(r_rem);
    assign y_in  = y_e < H_C;

    // Head: finish the partly drawn row.
    assign wx   = W_C - x_e;
    assign hp   = (rem_e < wx) ? rem_e : wx;
    assign hx   = x_e + hp;
    assign wrap = hx >= W_C;
    assign hx_n = wrap ? '0 : hx;
    assign hy_n = y_e + CALC_W'(wrap);
    assign hrem = rem_e - hp;

    // Body: whole rows, clipped at the raster bottom.
    assign rows_q = CALC_W'(r_dv);
    assign room   = H_C - y_e;
    assign rows   = (rows_q < room) ? rows_q : room;
    assign by     = y_e + rows;

    // Row count by reciprocal multiplication, then the pixels left over.
    assign prod   = 18'(r_rem) * 18'(DIV_M);
    assign q_full = prod >> DIV_K;
    assign pr_c   = rem_e - CALC_W'(r_dv) * W_C;

    assign head_go = (r_x != '0) && (r_rem != '0);
    assign body_go = (r_x == '0) && (rem_e >= W_C) && y_in;
    assign tail_go = (r_rem != '0) && y_in;
    assign frow_go = r_fill && y_in && (r_x != '0);
    assign fblk_go = r_fill && y_in;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && !r_ff) begin
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (!head_go || slot_free) begin
                    n_state = ST_BODY_CHK;
                end
            end
            ST_BODY_CHK: begin
                n_state = body_go ? ST_DIV : ST_TAIL;
            end
            ST_DIV: begin
                if (r_cnt) begin
                    n_state = ST_BODY;
                end
            end
            ST_BODY: begin
                if (slot_free) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (!tail_go || slot_free) begin
                    n_state = ST_FROW;
                end
            end
            ST_FROW: begin
                if (!frow_go || slot_free) begin
                    n_state = ST_FBLK;
                end
            end
            ST_FBLK: begin
                if (!fblk_go || slot_free) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_rem   = r_rem;
        n_white = r_white;
        n_fill  = r_fill;
        n_last  = r_last;
        n_ff    = r_ff;
        n_dv    = r_dv;
        n_pr    = r_pr;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        more    = 1'b0;
        done    = 1'b0;
        seg     = mk_seg(r_org_x, r_org_y, '0, y_e, W_C, CALC_W'(1), r_white, 1'b0, 1'b0);
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (r_ff) begin
                        // Frame already complete: the item is dropped, but the last
                        // pair still rewinds the cursor.
                        if (i_in.last_pair) begin
                            n_x  = '0;
                            n_y  = '0;
                            n_ff = 1'b0;
                        end
                    end else begin
                        n_rem   = i_in.run_count;
                        n_white = i_in.run_color != '0;
                        n_last  = i_in.last_pair;
                        n_fill  = i_in.last_pair ||
                                  ((i_in.run_count == '0) && (i_in.run_color == '0));
                    end
                end
            end
            ST_HEAD: begin
                if (head_go && slot_free) begin
                    more  = (hy_n < H_C) && ((hrem != '0) || r_fill);
                    done  = hy_n >= H_C;
                    emit  = 1'b1;
                    seg   = mk_seg(r_org_x, r_org_y, x_e, y_e, hp, CALC_W'(1),
                                   r_white, done, !more);
                    n_x   = hx_n[XW-1:0];
                    n_y   = hy_n[YW-1:0];
                    n_rem = hrem[7:0];
                end
            end
            ST_BODY_CHK: begin
                if (body_go) begin
                    n_cnt = 1'b0;
                end
            end
            ST_DIV: begin
                if (!r_cnt) begin
                    n_dv = q_full[7:0];
                end else begin
                    n_pr = pr_c[7:0];
                end
                n_cnt = 1'b1;
            end
            ST_BODY: begin
                if (slot_free) begin
                    more  = (by < H_C) && ((r_pr != '0) || r_fill);
                    done  = by >= H_C;
                    emit  = 1'b1;
                    seg   = mk_seg(r_org_x, r_org_y, '0, y_e, W_C, rows,
                                   r_white, done, !more);
                    n_y   = by[YW-1:0];
                    n_rem = r_pr;
                end
            end
            ST_TAIL: begin
                if (tail_go && slot_free) begin
                    emit = 1'b1;
                    seg  = mk_seg(r_org_x, r_org_y, '0, y_e, rem_e, CALC_W'(1),
                                  r_white, 1'b0, !r_fill);
                    n_x  = XW'(r_rem);
                end
            end
            ST_FROW: begin
                if (frow_go && slot_free) begin
                    more = (y_e + CALC_W'(1)) < H_C;
                    emit = 1'b1;
                    seg  = mk_seg(r_org_x, r_org_y, x_e, y_e, wx, CALC_W'(1),
                                  1'b0, !more, !more);
                    n_x  = '0;
                    n_y  = r_y + YW'(1);
                end
            end
            ST_FBLK: begin
                if (fblk_go && slot_free) begin
                    emit = 1'b1;
                    seg  = mk_seg(r_org_x, r_org_y, '0, y_e, W_C, room,
                                  1'b0, 1'b1, 1'b1);
                    n_y  = H_C[YW-1:0];
                end
            end
            ST_FIN: begin
                if (!y_in) begin
                    n_ff = 1'b1;
                end
                if (r_last) begin
                    n_x  = '0;
                    n_y  = '0;
                    n_ff = 1'b0;
                end
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_ff        <= 1'b0;
            r_cnt       <= 1'b0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_ff    <= n_ff;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                    CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                    default:      r_org_x <= r_org_x;
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_white <= n_white;
        r_fill  <= n_fill;
        r_last  <= n_last;
        r_dv    <= n_dv;
        r_pr    <= n_pr;
        if (emit) begin
            r_out <= seg;
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* rtl/rle_r2s_chk.sv */
// Port-level checker of the run-length raster decoder, bound to the top level.
// Depends on rle_r2s_pkg and on the assertion macros header.
`default_nettype none
`include "rle_run_to_raster_segments_macros.svh"

module rle_r2s_chk
    import rle_r2s_pkg::*;
#(
    parameter int RASTER_WIDTH  = 240,
    parameter int RASTER_HEIGHT = 320
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_seg_out o_out
);

    localparam int         RH   = RASTER_HEIGHT;
    localparam logic [7:0] W_LO = RASTER_WIDTH[7:0];

    logic out_stall;
    logic acc_empty;
    logic done_seg;
    logic blk_seg;

    assign out_stall = o_out_valid && !i_out_ready;
    assign acc_empty = i_in_valid && o_in_ready && !o_out_valid;
    assign done_seg  = o_out_valid && o_out.frame_done;
    assign blk_seg   = o_out_valid && (o_out.seg_rows > 9'd1) && (RH < 512);

    // A result waiting in the output register keeps its value until taken.
    `RRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out))

    // Taking an item while the output is empty puts no result out on the next cycle.
    `RRS_ASSERT_NEXT(a_no_result_at_accept, i_clk, i_rst_n, acc_empty, !o_out_valid)

    // The result that completes the frame always closes its item.
    `RRS_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, done_seg, o_out.item_last)

    // With a raster height below 512, only full-width blocks span more than one row.
    `RRS_ASSERT_NOW(a_block_full_width, i_clk, i_rst_n, blk_seg, o_out.seg_length == W_LO)

endmodule

bind rle_run_to_raster_segments rle_r2s_chk #(
    .RASTER_WIDTH  (RASTER_WIDTH),
    .RASTER_HEIGHT (RASTER_HEIGHT)
) u_rle_r2s_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
